// ----- rtl/imbf_pkg.sv -----
// shared constants and types of the inverse map bucket fill block
`default_nettype none

package imbf_pkg;

    localparam int FIELD_W = 16;
    localparam int BKT_W   = 8;
    localparam int SLOT_W  = 3;
    localparam int FILL_W  = 4;
    localparam int ENTRY_W = 18;
    localparam int VAL_W   = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [FIELD_W-1:0] RANGE_FIRST_RST = 16'd0;
    localparam logic [FIELD_W-1:0] RANGE_LAST_RST  = 16'd255;
    localparam logic [FIELD_W-1:0] ROW_BASE_RST    = 16'd0;

    localparam logic signed [ENTRY_W-1:0] ENTRY_NONE = -18'sd1;

    typedef enum logic
    {
        ACT_ADD  = 1'b0,
        ACT_READ = 1'b1
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_RANGE_FIRST = 2'd0,
        CFG_RANGE_LAST  = 2'd1,
        CFG_ROW_BASE    = 2'd2
    } cfg_index_t;

endpackage

`default_nettype wire

// ----- rtl/imbf_if.sv -----
// request and response channel interfaces
`default_nettype none

interface imbf_req_if;
    logic                                valid;
    logic                                ready;
    imbf_pkg::action_t                   action;
    logic [imbf_pkg::FIELD_W-1:0]        source_row;
    logic [imbf_pkg::FIELD_W-1:0]        target_id;
    logic [imbf_pkg::BKT_W-1:0]          read_bucket;
    logic [imbf_pkg::SLOT_W-1:0]         read_slot;

    modport source
    (
        output valid, action, source_row, target_id, read_bucket, read_slot,
        input  ready
    );
    modport sink
    (
        input  valid, action, source_row, target_id, read_bucket, read_slot,
        output ready
    );
endinterface

interface imbf_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                stored;
    logic                                out_of_range;
    logic                                overflow;
    logic [imbf_pkg::BKT_W-1:0]          bucket_index;
    logic [imbf_pkg::SLOT_W-1:0]         slot_index;
    logic [imbf_pkg::FILL_W-1:0]         bucket_fill;
    logic signed [imbf_pkg::ENTRY_W-1:0] entry_value;
    logic [imbf_pkg::FILL_W-1:0]         largest_fill;

    modport source
    (
        output valid, stored, out_of_range, overflow, bucket_index, slot_index,
               bucket_fill, entry_value, largest_fill,
        input  ready
    );
    modport sink
    (
        input  valid, stored, out_of_range, overflow, bucket_index, slot_index,
               bucket_fill, entry_value, largest_fill,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/imbf_count_mem.sv -----
// bucket count memory with a clearing sweep after reset
`default_nettype none

module imbf_count_mem #(
    parameter int BUCKETS = 256,
    parameter int CW      = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(BUCKETS)-1:0] rd_addr,
    output logic      [CW-1:0]              rd_data,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(BUCKETS)-1:0] wr_addr,
    input  wire logic [CW-1:0]              wr_data,
    output logic                            busy
);

    localparam int BW = $clog2(BUCKETS);

    logic [CW-1:0] mem [BUCKETS];
    logic [CW-1:0] rd_data_reg;
    logic          clr_busy_reg;
    logic          clr_busy_next;
    logic [BW-1:0] clr_addr_reg;
    logic [BW-1:0] clr_addr_next;
    logic          mem_we;
    logic [BW-1:0] mem_waddr;
    logic [CW-1:0] mem_wdata;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == BW'(BUCKETS - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (clr_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = wr_en;
            mem_waddr = wr_addr;
            mem_wdata = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

`default_nettype wire

// ----- rtl/imbf_entry_mem.sv -----
// bucket slot entry memory, one write and one registered read per cycle
`default_nettype none

module imbf_entry_mem #(
    parameter int DEPTH = 2048,
    parameter int DW    = 17
) (
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DW-1:0]            rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DW-1:0]            wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/inverse_map_bucket_fill_top.sv -----
// inverse map bucket fill: range check, count update with forwarding, result register
// an accepted item passes the stage 1 registers, then the output register; a stalled rsp holds it
// throughput: one item per cycle unless rsp stalls; one count read-modify-write per item
// the count memory read at accept is forwarded from the write of the item just ahead
// reset: config registers go to 0 / 255 / 0, then a sweep clears every bucket
// count with req.ready held low; slot entries are not cleared
`default_nettype none

module inverse_map_bucket_fill_top #(
    parameter int BUCKETS = 256,
    parameter int SLOTS   = 8,
    parameter int ID_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    imbf_req_if.sink                             req,
    imbf_rsp_if.source                           rsp,
    input  wire logic                            cfg_we,
    input  wire logic [imbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [imbf_pkg::FIELD_W-1:0]    cfg_data
);

    localparam int IDW = (ID_BITS < imbf_pkg::FIELD_W) ? ID_BITS : imbf_pkg::FIELD_W;
    localparam int BW  = $clog2(BUCKETS);
    localparam int CW  = $clog2(SLOTS + 1);
    localparam int AW  = $clog2(BUCKETS * SLOTS);
    localparam int VW  = imbf_pkg::VAL_W;

    // configuration
    logic [imbf_pkg::FIELD_W-1:0] range_first_reg;
    logic [imbf_pkg::FIELD_W-1:0] range_last_reg;
    logic [imbf_pkg::FIELD_W-1:0] row_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_first_reg <= imbf_pkg::RANGE_FIRST_RST;
            range_last_reg  <= imbf_pkg::RANGE_LAST_RST;
            row_base_reg    <= imbf_pkg::ROW_BASE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                imbf_pkg::CFG_RANGE_FIRST: range_first_reg <= cfg_data;
                imbf_pkg::CFG_RANGE_LAST:  range_last_reg  <= cfg_data;
                imbf_pkg::CFG_ROW_BASE:    row_base_reg    <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // stage 1 and output registers
    logic          s1_valid_reg;
    logic          s1_valid_next;
    logic          s1_add_reg;
    logic          s1_in_range_reg;
    logic          s1_rd_oor_reg;
    logic [BW-1:0] s1_b_reg;
    logic [imbf_pkg::BKT_W-1:0]  s1_rb_reg;
    logic [imbf_pkg::SLOT_W-1:0] s1_rs_reg;
    logic [VW-1:0] s1_val_reg;
    logic          fwd_cnt_hit_reg;
    logic [CW-1:0] fwd_cnt_reg;
    logic          fwd_ent_hit_reg;
    logic [VW-1:0] fwd_ent_reg;
    logic [CW-1:0] max_fill_reg;
    logic [CW-1:0] max_fill_next;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            out_stored_reg;
    logic                            out_oor_reg;
    logic                            out_ovf_reg;
    logic [imbf_pkg::BKT_W-1:0]      out_bkt_reg;
    logic [imbf_pkg::SLOT_W-1:0]     out_slot_reg;
    logic [imbf_pkg::FILL_W-1:0]     out_fill_reg;
    logic signed [imbf_pkg::ENTRY_W-1:0] out_val_reg;
    logic [imbf_pkg::FILL_W-1:0]     out_max_reg;

    // accept-side logic
    logic          clr_busy;
    logic          s1_go;
    logic          accept;
    logic          in_add;
    logic [IDW-1:0] id;
    logic [IDW-1:0] lo;
    logic [IDW-1:0] hi;
    logic [IDW-1:0] diff;
    logic          in_range;
    logic          rd_oor;
    logic [BW-1:0] add_b;
    logic [BW-1:0] rd_b;
    logic [BW-1:0] cnt_raddr;
    logic [AW-1:0] ent_raddr;
    logic [VW-1:0] in_val;

    // stage 1 logic
    logic [CW-1:0] cnt_rd_data;
    logic [VW-1:0] ent_rd_data;
    logic [CW-1:0] cnt;
    logic [VW-1:0] ent;
    logic [CW-1:0] cnt_inc;
    logic          full;
    logic          store;
    logic          wr_en;
    logic [AW-1:0] ent_waddr;

    logic                            res_stored;
    logic                            res_oor;
    logic                            res_ovf;
    logic [imbf_pkg::BKT_W-1:0]      res_bkt;
    logic [imbf_pkg::SLOT_W-1:0]     res_slot;
    logic [imbf_pkg::FILL_W-1:0]     res_fill;
    logic signed [imbf_pkg::ENTRY_W-1:0] res_val;

    assign s1_go     = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !clr_busy && (!s1_valid_reg || s1_go);
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        in_add    = (req.action == imbf_pkg::ACT_ADD);
        id        = req.target_id[IDW-1:0];
        lo        = range_first_reg[IDW-1:0];
        hi        = range_last_reg[IDW-1:0];
        diff      = id - lo;
        in_range  = (id >= lo) && (id <= hi) && (32'(diff) < 32'(BUCKETS));
        rd_oor    = (32'(req.read_bucket) >= 32'(BUCKETS))
                 || (32'(req.read_slot) >= 32'(SLOTS));
        add_b     = BW'(diff);
        rd_b      = BW'(req.read_bucket);
        cnt_raddr = in_add ? add_b : rd_b;
        ent_raddr = AW'(AW'(rd_b) * AW'(SLOTS)) + AW'(req.read_slot);
        in_val    = VW'(req.source_row) + VW'(row_base_reg);
    end

    always_comb
    begin
        cnt       = fwd_cnt_hit_reg ? fwd_cnt_reg : cnt_rd_data;
        ent       = fwd_ent_hit_reg ? fwd_ent_reg : ent_rd_data;
        cnt_inc   = cnt + 1'b1;
        full      = (32'(cnt) >= 32'(SLOTS));
        store     = s1_add_reg && s1_in_range_reg && !full;
        wr_en     = s1_go && store;
        ent_waddr = AW'(AW'(s1_b_reg) * AW'(SLOTS)) + AW'(cnt);
        max_fill_next = (wr_en && (cnt_inc > max_fill_reg)) ? cnt_inc : max_fill_reg;
    end

    always_comb
    begin
        res_stored = 1'b0;
        res_oor    = 1'b0;
        res_ovf    = 1'b0;
        res_bkt    = '0;
        res_slot   = '0;
        res_fill   = '0;
        res_val    = imbf_pkg::ENTRY_NONE;
        if (s1_add_reg)
        begin
            if (!s1_in_range_reg)
            begin
                res_oor = 1'b1;
            end
            else if (full)
            begin
                res_ovf  = 1'b1;
                res_bkt  = imbf_pkg::BKT_W'(s1_b_reg);
                res_fill = imbf_pkg::FILL_W'(cnt);
            end
            else
            begin
                res_stored = 1'b1;
                res_bkt    = imbf_pkg::BKT_W'(s1_b_reg);
                res_slot   = imbf_pkg::SLOT_W'(cnt);
                res_fill   = imbf_pkg::FILL_W'(cnt_inc);
                res_val    = imbf_pkg::ENTRY_W'(s1_val_reg);
            end
        end
        else
        begin
            res_bkt  = s1_rb_reg;
            res_slot = s1_rs_reg;
            if (s1_rd_oor_reg)
            begin
                res_oor = 1'b1;
            end
            else
            begin
                res_fill = imbf_pkg::FILL_W'(cnt);
                // slots at or past the count were never written
                if (7'(s1_rs_reg) < 7'(cnt))
                begin
                    res_val = imbf_pkg::ENTRY_W'(ent);
                end
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_fill_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            max_fill_reg  <= max_fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_add_reg      <= in_add;
            s1_in_range_reg <= in_range;
            s1_rd_oor_reg   <= rd_oor;
            s1_b_reg        <= cnt_raddr;
            s1_rb_reg       <= req.read_bucket;
            s1_rs_reg       <= req.read_slot;
            s1_val_reg      <= in_val;
            // memory read sees the old value if the item ahead writes the same place now
            fwd_cnt_hit_reg <= wr_en && (s1_b_reg == cnt_raddr);
            fwd_cnt_reg     <= cnt_inc;
            fwd_ent_hit_reg <= wr_en && (ent_waddr == ent_raddr);
            fwd_ent_reg     <= s1_val_reg;
        end
        if (s1_go)
        begin
            out_stored_reg <= res_stored;
            out_oor_reg    <= res_oor;
            out_ovf_reg    <= res_ovf;
            out_bkt_reg    <= res_bkt;
            out_slot_reg   <= res_slot;
            out_fill_reg   <= res_fill;
            out_val_reg    <= res_val;
            out_max_reg    <= imbf_pkg::FILL_W'(max_fill_next);
        end
    end

    imbf_count_mem #(
        .BUCKETS (BUCKETS),
        .CW      (CW)
    ) u_count_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (cnt_raddr),
        .rd_data (cnt_rd_data),
        .wr_en   (wr_en),
        .wr_addr (s1_b_reg),
        .wr_data (cnt_inc),
        .busy    (clr_busy)
    );

    imbf_entry_mem #(
        .DEPTH   (BUCKETS * SLOTS),
        .DW      (VW)
    ) u_entry_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (ent_raddr),
        .rd_data (ent_rd_data),
        .wr_en   (wr_en),
        .wr_addr (ent_waddr),
        .wr_data (s1_val_reg)
    );

    assign rsp.valid        = out_valid_reg;
    assign rsp.stored       = out_stored_reg;
    assign rsp.out_of_range = out_oor_reg;
    assign rsp.overflow     = out_ovf_reg;
    assign rsp.bucket_index = out_bkt_reg;
    assign rsp.slot_index   = out_slot_reg;
    assign rsp.bucket_fill  = out_fill_reg;
    assign rsp.entry_value  = out_val_reg;
    assign rsp.largest_fill = out_max_reg;

endmodule

`default_nettype wire

// ----- rtl/imbf_checker.sv -----
// port-level assertions for the inverse map bucket fill top, with its bind
`default_nettype none

module imbf_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            rsp_valid,
    input wire logic                            rsp_ready,
    input wire logic                            rsp_stored,
    input wire logic                            rsp_out_of_range,
    input wire logic                            rsp_overflow,
    input wire logic [imbf_pkg::FILL_W-1:0]     rsp_bucket_fill,
    input wire logic signed [imbf_pkg::ENTRY_W-1:0] rsp_entry_value,
    input wire logic [imbf_pkg::FILL_W-1:0]     rsp_largest_fill
);

    // at most one of the three status flags per item
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $countones({rsp_stored, rsp_out_of_range, rsp_overflow}) <= 1)
        else $error("more than one status flag set");

    // a stored entry carries a real value and a non-empty bucket
    a_stored_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stored |->
            rsp_entry_value != imbf_pkg::ENTRY_NONE && rsp_bucket_fill != '0)
        else $error("stored item without value or fill");

    // out of range items report nothing from the store
    a_oor_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_out_of_range |->
            rsp_entry_value == imbf_pkg::ENTRY_NONE && rsp_bucket_fill == '0)
        else $error("out of range item reports store data");

    // the running maximum covers every reported bucket count
    a_max_covers: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_largest_fill >= rsp_bucket_fill)
        else $error("largest fill below bucket fill");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

endmodule

bind inverse_map_bucket_fill_top imbf_checker u_imbf_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_stored       (rsp.stored),
    .rsp_out_of_range (rsp.out_of_range),
    .rsp_overflow     (rsp.overflow),
    .rsp_bucket_fill  (rsp.bucket_fill),
    .rsp_entry_value  (rsp.entry_value),
    .rsp_largest_fill (rsp.largest_fill)
);

`default_nettype wire

// ----- verif/inverse_map_bucket_fill_top_test.sv -----
// self-checking testbench of inverse_map_bucket_fill_top: directed table, then random phases
`timescale 1ns / 1ps

module inverse_map_bucket_fill_top_test;

    import imbf_pkg::*;

    localparam int NUM_BUCKETS = 256;
    localparam int NUM_SLOTS   = 8;
    localparam int NUM_PROBES  = 20;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed
    {
        action_t              action;
        logic [FIELD_W-1:0]   source_row;
        logic [FIELD_W-1:0]   target_id;
        logic [BKT_W-1:0]     read_bucket;
        logic [SLOT_W-1:0]    read_slot;
    } req_item_t;

    typedef struct packed
    {
        logic                       stored;
        logic                       out_of_range;
        logic                       overflow;
        logic [BKT_W-1:0]           bucket_index;
        logic [SLOT_W-1:0]          slot_index;
        logic [FILL_W-1:0]          bucket_fill;
        logic signed [ENTRY_W-1:0]  entry_value;
        logic [FILL_W-1:0]          largest_fill;
    } outcome_t;

    typedef struct packed
    {
        req_item_t  item;
        logic       fixed;
        outcome_t   want;
    } probe_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FIELD_W-1:0]   cfg_data;

    imbf_req_if req();
    imbf_rsp_if rsp();

    inverse_map_bucket_fill_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // shadow of the block: config, bucket counts, stored rows, peak count
    int unsigned cfg_first = RANGE_FIRST_RST;
    int unsigned cfg_last  = RANGE_LAST_RST;
    int unsigned cfg_base  = ROW_BASE_RST;
    int unsigned fill_count [NUM_BUCKETS];
    logic signed [ENTRY_W-1:0] row_store [NUM_BUCKETS*NUM_SLOTS];
    int unsigned peak_fill = 0;

    outcome_t pending_outcomes [$];
    probe_t   probe_table [NUM_PROBES];
    logic     probe_fixed;
    outcome_t probe_want;

    int unsigned errors = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count = 0;
    bit          idle_on = 1'b1;
    int unsigned hot_spot = 0;
    int unsigned hot_span = 31;

    function automatic outcome_t bucket_outcome(input req_item_t it);
        outcome_t o;
        int unsigned id, b, c, s;
        logic [FIELD_W:0] sum;
        o = '0;
        o.entry_value = ENTRY_NONE;
        if (it.action == ACT_ADD)
        begin
            id = it.target_id;
            if (id < cfg_first || id > cfg_last || id - cfg_first >= NUM_BUCKETS)
            begin
                o.out_of_range = 1'b1;
            end
            else
            begin
                b = id - cfg_first;
                c = fill_count[b];
                o.bucket_index = b[BKT_W-1:0];
                if (c >= NUM_SLOTS)
                begin
                    o.overflow    = 1'b1;
                    o.bucket_fill = c[FILL_W-1:0];
                end
                else
                begin
                    sum = it.source_row + cfg_base[FIELD_W-1:0];
                    row_store[b*NUM_SLOTS + c] = {1'b0, sum};
                    fill_count[b] = c + 1;
                    if (c + 1 > peak_fill)
                        peak_fill = c + 1;
                    o.stored      = 1'b1;
                    o.slot_index  = c[SLOT_W-1:0];
                    o.bucket_fill = 4'(c + 1);
                    o.entry_value = {1'b0, sum};
                end
            end
        end
        else
        begin
            b = it.read_bucket;
            s = it.read_slot;
            c = fill_count[b];
            o.bucket_index = it.read_bucket;
            o.slot_index   = it.read_slot;
            o.bucket_fill  = c[FILL_W-1:0];
            // only slots below the count were ever written
            if (s < c)
                o.entry_value = row_store[b*NUM_SLOTS + s];
        end
        o.largest_fill = peak_fill[FILL_W-1:0];
        return o;
    endfunction

    function automatic req_item_t add_op(input int unsigned row, input int unsigned id);
        req_item_t it;
        it = '0;
        it.action     = ACT_ADD;
        it.source_row = row[FIELD_W-1:0];
        it.target_id  = id[FIELD_W-1:0];
        return it;
    endfunction

    function automatic req_item_t read_op(input int unsigned b, input int unsigned s);
        req_item_t it;
        it = '0;
        it.action      = ACT_READ;
        it.read_bucket = b[BKT_W-1:0];
        it.read_slot   = s[SLOT_W-1:0];
        return it;
    endfunction

    function automatic outcome_t res(input bit st, input bit oor, input bit ovf,
                                     input int b, input int s, input int f,
                                     input int v, input int lf);
        outcome_t o;
        o.stored       = st;
        o.out_of_range = oor;
        o.overflow     = ovf;
        o.bucket_index = b[BKT_W-1:0];
        o.slot_index   = s[SLOT_W-1:0];
        o.bucket_fill  = f[FILL_W-1:0];
        o.entry_value  = 18'(v);
        o.largest_fill = lf[FILL_W-1:0];
        return o;
    endfunction

    // mostly short gaps, a few long ones, none while idling is off
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic req_item_t random_item();
        req_item_t it;
        int unsigned id, b, c;
        int r;
        it.source_row  = FIELD_W'($urandom);
        it.target_id   = FIELD_W'($urandom);
        it.read_bucket = BKT_W'($urandom);
        it.read_slot   = SLOT_W'($urandom);
        if ($urandom_range(0, 9) == 0)
            it.source_row = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        if ($urandom_range(0, 99) < 55)
        begin
            it.action = ACT_ADD;
            r = $urandom_range(0, 99);
            if (r < 60)
                id = cfg_first + hot_spot + $urandom_range(0, hot_span);
            else if (r < 75)
                id = cfg_first + $urandom_range(0, 255);
            else if (r < 85)
            begin
                case ($urandom_range(0, 5))
                    0:       id = cfg_first;
                    1:       id = cfg_last;
                    2:       id = cfg_first - 1;
                    3:       id = cfg_last + 1;
                    4:       id = cfg_first + NUM_BUCKETS - 1;
                    default: id = cfg_first + NUM_BUCKETS;
                endcase
            end
            else
                id = $urandom;
            it.target_id = id[FIELD_W-1:0];
        end
        else
        begin
            it.action = ACT_READ;
            if ($urandom_range(0, 99) < 70)
            begin
                b = hot_spot + $urandom_range(0, hot_span);
                it.read_bucket = b[BKT_W-1:0];
            end
            c = fill_count[it.read_bucket];
            if (c > 0 && $urandom_range(0, 1))
                it.read_slot = 3'($urandom_range(0, c - 1));
        end
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        if (errors < 50)
            $display("mismatch at result %0d: %s", results_seen, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_item(input req_item_t it, input logic fixed, input outcome_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid       <= 1'b1;
        req.action      <= it.action;
        req.source_row  <= it.source_row;
        req.target_id   <= it.target_id;
        req.read_bucket <= it.read_bucket;
        req.read_slot   <= it.read_slot;
        probe_fixed     <= fixed;
        probe_want      <= want;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        req.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_config(input int unsigned first, input int unsigned last,
                                input int unsigned base);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RANGE_FIRST;
        cfg_data  <= first[FIELD_W-1:0];
        @(negedge clk);
        cfg_index <= CFG_RANGE_LAST;
        cfg_data  <= last[FIELD_W-1:0];
        @(negedge clk);
        cfg_index <= CFG_ROW_BASE;
        cfg_data  <= base[FIELD_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input int unsigned first, input int unsigned last,
                             input int unsigned base, input int count,
                             input int unsigned spot, input int unsigned span,
                             input bit calm, input bit pause_mid);
        write_config(first, last, base);
        hot_spot = spot;
        hot_span = span;
        idle_on  = !calm;
        for (int i = 0; i < count; i++)
        begin
            if (pause_mid && i == count / 2)
                drain_results();
            send_item(random_item(), 1'b0, '0);
        end
        drain_results();
        idle_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("inverse_map_bucket_fill_top regression: fail");
            $finish;
        end
    end

    // result checking first, then the item taken at this edge
    always @(posedge clk)
    begin
        outcome_t  o;
        req_item_t it;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_outcomes.size() == 0)
                report_mismatch("result with no item waiting");
            else
            begin
                o = pending_outcomes.pop_front();
                check_field("stored", rsp.stored, o.stored);
                check_field("out_of_range", rsp.out_of_range, o.out_of_range);
                check_field("overflow", rsp.overflow, o.overflow);
                check_field("bucket_index", rsp.bucket_index, o.bucket_index);
                check_field("slot_index", rsp.slot_index, o.slot_index);
                check_field("bucket_fill", rsp.bucket_fill, o.bucket_fill);
                check_field("entry_value", rsp.entry_value, o.entry_value);
                check_field("largest_fill", rsp.largest_fill, o.largest_fill);
            end
            results_seen++;
        end
        if (rst_n && cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_RANGE_FIRST: cfg_first = cfg_data;
                CFG_RANGE_LAST:  cfg_last  = cfg_data;
                CFG_ROW_BASE:    cfg_base  = cfg_data;
                default: ;
            endcase
        end
        if (rst_n && req.valid && req.ready)
        begin
            it.action      = req.action;
            it.source_row  = req.source_row;
            it.target_id   = req.target_id;
            it.read_bucket = req.read_bucket;
            it.read_slot   = req.read_slot;
            o = bucket_outcome(it);
            pending_outcomes.push_back(probe_fixed ? probe_want : o);
        end
    end

    initial
    begin : result_stall
        int n;
        rsp.ready = 1'b0;
        forever
        begin
            n = pick_gap();
            if (n > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            rsp.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_RANGE_FIRST;
        cfg_data        = '0;
        req.valid       = 1'b0;
        req.action      = ACT_ADD;
        req.source_row  = '0;
        req.target_id   = '0;
        req.read_bucket = '0;
        req.read_slot   = '0;
        probe_fixed     = 1'b0;
        probe_want      = '0;
        foreach (fill_count[i])
            fill_count[i] = 0;

        // default range 0..255, row offset 0
        probe_table = '{
            '{read_op(0, 0),        1'b1, res(0, 0, 0, 0, 0, 0, -1, 0)},
            '{add_op(0, 0),         1'b1, res(1, 0, 0, 0, 0, 1, 0, 1)},
            '{add_op(65535, 255),   1'b1, res(1, 0, 0, 255, 0, 1, 65535, 1)},
            '{add_op(5, 256),       1'b1, res(0, 1, 0, 0, 0, 0, -1, 1)},
            '{add_op(65535, 65535), 1'b1, res(0, 1, 0, 0, 0, 0, -1, 1)},
            '{read_op(255, 0),      1'b0, '0},
            '{read_op(255, 1),      1'b1, res(0, 0, 0, 255, 1, 1, -1, 1)},
            '{add_op(100, 7),       1'b0, '0},
            '{add_op(200, 7),       1'b0, '0},
            '{add_op(300, 7),       1'b0, '0},
            '{add_op(400, 7),       1'b0, '0},
            '{add_op(500, 7),       1'b0, '0},
            '{add_op(600, 7),       1'b0, '0},
            '{add_op(700, 7),       1'b0, '0},
            '{add_op(800, 7),       1'b0, '0},
            '{add_op(42, 7),        1'b1, res(0, 0, 1, 7, 0, 8, -1, 8)},
            '{read_op(7, 7),        1'b0, '0},
            '{read_op(7, 0),        1'b0, '0},
            '{add_op(32768, 0),     1'b0, '0},
            '{read_op(0, 1),        1'b0, '0}
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (probe_table[i])
            send_item(probe_table[i].item, probe_table[i].fixed, probe_table[i].want);
        drain_results();

        run_phase(0, 255, 0, 320, $urandom_range(0, 224), 31, 1'b0, 1'b0);
        run_phase(100, 300, 65535, 260, $urandom_range(0, 224), 31, 1'b1, 1'b0);
        run_phase(65535, 65535, 1, 160, 0, 0, 1'b0, 1'b0);
        // empty range: every add is dropped
        run_phase(1, 0, 300, 100, $urandom_range(0, 224), 31, 1'b0, 1'b0);
        run_phase(0, 65535, $urandom_range(0, 65535), 350, $urandom_range(0, 192), 63,
                  1'b0, 1'b0);
        run_phase(40000, 40100, 0, 340, $urandom_range(0, 224), 31, 1'b0, 1'b1);

        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("inverse_map_bucket_fill_top regression: pass");
        else
            $display("inverse_map_bucket_fill_top regression: fail");
        $finish;
    end

endmodule
